// ----- src/lfs_pkg.sv -----
// ----------------------------------------------------------------------------
// lfs_pkg: shared types and constants for linear fitness scaling
// Widths, limits, sequencer states and arithmetic unit controls.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int POP_SIZE = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int FIT_W    = 23;
  localparam int SUM_W    = 29;
  localparam int ADJ_W    = 24;
  localparam int TOT_W    = 30;
  localparam int MULT_W   = 11;
  localparam int ACC_W    = 58;
  localparam int DIV_W    = 31;
  localparam int STEP_W   = 6;

  localparam logic [MULT_W-1:0] MULT_RESET = 11'd512;
  localparam logic [MULT_W-1:0] MULT_LOW   = 11'd256;
  localparam logic [MULT_W-1:0] MULT_HIGH  = 11'd1024;
  localparam logic [FIT_W-1:0]  ONE_Q16    = 23'd65536;
  localparam logic [ADJ_W-1:0]  ADJ_MAX    = 24'd13107200;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_AVG_GO,
    ST_AVG,
    ST_PREP,
    ST_SETUP,
    ST_READ,
    ST_FETCH,
    ST_TERM,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

endpackage

// ----- src/lfs_ram.sv -----
// ----------------------------------------------------------------------------
// lfs_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/lfs_arith.sv -----
// ----------------------------------------------------------------------------
// lfs_arith: shared serial multiply / divide unit
// Shift-add multiply and restoring divide over one shared adder, one bit
// per cycle. Multiply takes DIV_W steps, divide takes ACC_W steps.
// ----------------------------------------------------------------------------
module lfs_arith (
  input  logic                      clk,
  input  logic                      rst,
  input  lfs_pkg::arith_ctl_t       ctl,
  input  logic [lfs_pkg::ACC_W-1:0] a,
  input  logic [lfs_pkg::DIV_W-1:0] b,
  output logic                      done,
  output logic [lfs_pkg::ACC_W-1:0] result
);

  logic                        busy;
  lfs_pkg::arith_op_t          op_q;
  logic [lfs_pkg::ACC_W-1:0]   acc;
  logic [lfs_pkg::ACC_W-1:0]   a_sh;
  logic [lfs_pkg::DIV_W-1:0]   bq;
  logic [lfs_pkg::DIV_W-1:0]   rem;
  logic [lfs_pkg::STEP_W-1:0]  steps;

  logic [lfs_pkg::DIV_W:0]     rem_sh;
  logic [lfs_pkg::ACC_W-1:0]   add_x;
  logic [lfs_pkg::ACC_W-1:0]   add_y;
  logic                        cin;
  logic [lfs_pkg::ACC_W:0]     sum;

  always_comb begin
    rem_sh = {rem, acc[lfs_pkg::ACC_W-1]};
    if (op_q == lfs_pkg::OP_MUL) begin
      add_x = acc;
      add_y = a_sh;
      cin   = 1'b0;
    end else begin
      add_x = lfs_pkg::ACC_W'(rem_sh);
      add_y = ~lfs_pkg::ACC_W'(bq);
      cin   = 1'b1;
    end
    sum = {1'b0, add_x} + {1'b0, add_y} + (lfs_pkg::ACC_W+1)'(cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        op_q <= ctl.op;
        a_sh <= a;
        bq   <= b;
        rem  <= '0;
        if (ctl.op == lfs_pkg::OP_MUL) begin
          acc   <= '0;
          steps <= lfs_pkg::STEP_W'(lfs_pkg::DIV_W);
        end else begin
          acc   <= a;
          steps <= lfs_pkg::STEP_W'(lfs_pkg::ACC_W);
        end
      end else if (busy) begin
        if (op_q == lfs_pkg::OP_MUL) begin
          if (bq[0]) begin
            acc <= sum[lfs_pkg::ACC_W-1:0];
          end
          a_sh <= {a_sh[lfs_pkg::ACC_W-2:0], 1'b0};
          bq   <= {1'b0, bq[lfs_pkg::DIV_W-1:1]};
        end else begin
          if (sum[lfs_pkg::ACC_W]) begin
            rem <= sum[lfs_pkg::DIV_W-1:0];
            acc <= {acc[lfs_pkg::ACC_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[lfs_pkg::DIV_W-1:0];
            acc <= {acc[lfs_pkg::ACC_W-2:0], 1'b0};
          end
        end
        steps <= steps - 1'b1;
        if (steps == lfs_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("arith start while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("arith done without work");
  a_steps_live: assert property (@(posedge clk) disable iff (rst) busy |-> steps != '0)
    else $error("arith busy with no steps left");

endmodule

// ----- src/linear_fitness_scaling.sv -----
// ----------------------------------------------------------------------------
// linear_fitness_scaling: linear fitness scaling over a loaded population
// Loads one raw fitness word (Q7.16) per cycle until a word marked last or
// the 64th word, then finds max, first max index, min and truncated mean,
// and emits one scaled word (Q8.16, saturated) per individual in order with
// the statistics and a running total. The mean is found with a serial
// divide, and each scaled word needs a 31-step serial multiply plus a
// 58-step serial divide on the one shared add/subtract unit, plus a RAM
// read and setup. A word that passes through unchanged, or is clamped to
// zero, skips the multiply and divide. The input is not ready while results
// are being produced.
// ----------------------------------------------------------------------------
module linear_fitness_scaling (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfs_pkg::MULT_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lfs_pkg::FIT_W-1:0]  fitness,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lfs_pkg::IDX_W-1:0]  index,
  output logic [lfs_pkg::ADJ_W-1:0]  adjusted_fitness,
  output logic [lfs_pkg::FIT_W-1:0]  max_fitness,
  output logic [lfs_pkg::FIT_W-1:0]  min_fitness,
  output logic [lfs_pkg::FIT_W-1:0]  avg_fitness,
  output logic [lfs_pkg::IDX_W-1:0]  best_index,
  output logic [lfs_pkg::TOT_W-1:0]  running_total,
  output logic                       last_result
);

  lfs_pkg::state_t state, state_next;

  logic [lfs_pkg::MULT_W-1:0] fitness_multiple;
  logic [lfs_pkg::CNT_W-1:0]  item_count;
  logic [lfs_pkg::SUM_W-1:0]  fitness_sum;
  logic [lfs_pkg::FIT_W-1:0]  max_seen;
  logic [lfs_pkg::FIT_W-1:0]  min_seen;
  logic [lfs_pkg::IDX_W-1:0]  max_position;
  logic [lfs_pkg::FIT_W-1:0]  avg;

  logic [9:0]                 mult_sub;
  logic [32:0]                p_min;
  logic [33:0]                p_avg;
  logic signed [35:0]         k_off;
  logic                       normal;
  logic                       pass;
  logic                       mz_ok;
  logic [lfs_pkg::DIV_W-1:0]  den;
  logic [lfs_pkg::IDX_W-1:0]  idx;
  logic [lfs_pkg::FIT_W-1:0]  x_q;
  logic [32:0]                pterm;
  logic [lfs_pkg::ADJ_W-1:0]  adj_q;
  logic [lfs_pkg::TOT_W-1:0]  total_q;

  logic                       in_acc;
  logic                       out_acc;
  logic                       load_end;
  logic                       is_last_idx;
  logic [lfs_pkg::MULT_W-1:0] m_cl;
  logic [lfs_pkg::FIT_W-1:0]  mx_diff;
  logic signed [35:0]         t_val;
  logic                       bypass;
  logic                       ram_re;
  logic [lfs_pkg::FIT_W-1:0]  rdata;
  logic                       adj_load;
  logic [lfs_pkg::ADJ_W-1:0]  adj_value;

  lfs_pkg::arith_ctl_t        ar_ctl;
  logic [lfs_pkg::ACC_W-1:0]  ar_a;
  logic [lfs_pkg::DIV_W-1:0]  ar_b;
  logic                       ar_done;
  logic [lfs_pkg::ACC_W-1:0]  ar_result;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == lfs_pkg::ST_LOAD);
  assign out_valid   = (state == lfs_pkg::ST_EMIT);
  assign in_acc      = in_valid && in_ready;
  assign out_acc     = out_valid && out_ready;
  assign load_end    = last || ((item_count + 1'b1) == lfs_pkg::CNT_W'(lfs_pkg::POP_SIZE));
  assign is_last_idx = ((lfs_pkg::CNT_W'(idx) + 1'b1) == item_count);

  always_comb begin
    if (fitness_multiple < lfs_pkg::MULT_LOW) begin
      m_cl = lfs_pkg::MULT_LOW;
    end else if (fitness_multiple > lfs_pkg::MULT_HIGH) begin
      m_cl = lfs_pkg::MULT_HIGH;
    end else begin
      m_cl = fitness_multiple;
    end
    mx_diff = max_seen - avg;
    t_val   = $signed({3'b0, pterm}) + k_off;
    bypass  = pass || (!normal && !mz_ok);
  end

  lfs_ram #(
    .WIDTH(lfs_pkg::FIT_W),
    .DEPTH(lfs_pkg::POP_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (in_acc),
    .waddr(item_count[lfs_pkg::IDX_W-1:0]),
    .wdata(fitness),
    .re   (ram_re),
    .raddr(idx),
    .rdata(rdata)
  );

  lfs_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ar_ctl),
    .a     (ar_a),
    .b     (ar_b),
    .done  (ar_done),
    .result(ar_result)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      lfs_pkg::ST_LOAD: begin
        if (in_acc && load_end) begin
          state_next = lfs_pkg::ST_AVG_GO;
        end
      end
      lfs_pkg::ST_AVG_GO: state_next = lfs_pkg::ST_AVG;
      lfs_pkg::ST_AVG: begin
        if (ar_done) begin
          state_next = lfs_pkg::ST_PREP;
        end
      end
      lfs_pkg::ST_PREP:  state_next = lfs_pkg::ST_SETUP;
      lfs_pkg::ST_SETUP: state_next = lfs_pkg::ST_READ;
      lfs_pkg::ST_READ:  state_next = lfs_pkg::ST_FETCH;
      lfs_pkg::ST_FETCH: state_next = lfs_pkg::ST_TERM;
      lfs_pkg::ST_TERM: begin
        if (bypass || (normal && t_val[35])) begin
          state_next = lfs_pkg::ST_EMIT;
        end else begin
          state_next = lfs_pkg::ST_MUL;
        end
      end
      lfs_pkg::ST_MUL: begin
        if (ar_done) begin
          state_next = lfs_pkg::ST_DIV;
        end
      end
      lfs_pkg::ST_DIV: begin
        if (ar_done) begin
          state_next = lfs_pkg::ST_EMIT;
        end
      end
      lfs_pkg::ST_EMIT: begin
        if (out_acc) begin
          state_next = is_last_idx ? lfs_pkg::ST_LOAD : lfs_pkg::ST_READ;
        end
      end
      default: state_next = lfs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    ram_re       = 1'b0;
    ar_ctl.start = 1'b0;
    ar_ctl.op    = lfs_pkg::OP_MUL;
    ar_a         = '0;
    ar_b         = '0;
    adj_load     = 1'b0;
    adj_value    = '0;
    unique case (state)
      lfs_pkg::ST_AVG_GO: begin
        ar_ctl.start = 1'b1;
        ar_ctl.op    = lfs_pkg::OP_DIV;
        ar_a         = lfs_pkg::ACC_W'(fitness_sum);
        ar_b         = lfs_pkg::DIV_W'(item_count);
      end
      lfs_pkg::ST_READ: ram_re = 1'b1;
      lfs_pkg::ST_TERM: begin
        if (bypass) begin
          adj_load  = 1'b1;
          adj_value = lfs_pkg::ADJ_W'(x_q);
        end else if (normal) begin
          if (t_val[35]) begin
            adj_load = 1'b1;
          end else begin
            ar_ctl.start = 1'b1;
            ar_a         = lfs_pkg::ACC_W'(t_val[33:0]);
            ar_b         = lfs_pkg::DIV_W'(avg);
          end
        end else begin
          ar_ctl.start = 1'b1;
          ar_a         = lfs_pkg::ACC_W'(x_q - min_seen);
          ar_b         = lfs_pkg::DIV_W'(avg);
        end
      end
      lfs_pkg::ST_MUL: begin
        if (ar_done) begin
          ar_ctl.start = 1'b1;
          ar_ctl.op    = lfs_pkg::OP_DIV;
          ar_a         = ar_result;
          ar_b         = normal ? den : lfs_pkg::DIV_W'(avg - min_seen);
        end
      end
      lfs_pkg::ST_DIV: begin
        if (ar_done) begin
          adj_load = 1'b1;
          if (ar_result > lfs_pkg::ACC_W'(lfs_pkg::ADJ_MAX)) begin
            adj_value = lfs_pkg::ADJ_MAX;
          end else begin
            adj_value = ar_result[lfs_pkg::ADJ_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= lfs_pkg::ST_LOAD;
      fitness_multiple <= lfs_pkg::MULT_RESET;
      item_count       <= '0;
      fitness_sum      <= '0;
      max_seen         <= '0;
      min_seen         <= '1;
      max_position     <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        fitness_multiple <= cfg_data;
      end
      if (in_acc) begin
        item_count  <= item_count + 1'b1;
        fitness_sum <= fitness_sum + lfs_pkg::SUM_W'(fitness);
        if (fitness > max_seen) begin
          max_seen     <= fitness;
          max_position <= item_count[lfs_pkg::IDX_W-1:0];
        end
        if (fitness < min_seen) begin
          min_seen <= fitness;
        end
      end
      if (out_acc && is_last_idx) begin
        item_count   <= '0;
        fitness_sum  <= '0;
        max_seen     <= '0;
        min_seen     <= '1;
        max_position <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == lfs_pkg::ST_AVG && ar_done) begin
      avg <= ar_result[lfs_pkg::FIT_W-1:0];
    end
    if (state == lfs_pkg::ST_PREP) begin
      mult_sub <= 10'(m_cl - lfs_pkg::MULT_LOW);
      p_min    <= 33'(10'(m_cl - lfs_pkg::MULT_LOW)) * 33'(min_seen);
      p_avg    <= 34'(m_cl) * 34'(avg);
    end
    if (state == lfs_pkg::ST_SETUP) begin
      normal  <= (34'(p_min) + 34'({max_seen, 8'b0})) > p_avg;
      k_off   <= $signed({5'b0, max_seen, 8'b0}) - $signed({2'b0, p_avg});
      pass    <= (max_seen < avg) || (mx_diff < lfs_pkg::ONE_Q16);
      den     <= {mx_diff, 8'b0};
      mz_ok   <= avg > min_seen;
      idx     <= '0;
      total_q <= '0;
    end
    if (state == lfs_pkg::ST_FETCH) begin
      x_q   <= rdata;
      pterm <= 33'(mult_sub) * 33'(rdata);
    end
    if (adj_load) begin
      adj_q   <= adj_value;
      total_q <= total_q + lfs_pkg::TOT_W'(adj_value);
    end
    if (out_acc && !is_last_idx) begin
      idx <= idx + 1'b1;
    end
  end

  assign index            = idx;
  assign adjusted_fitness = adj_q;
  assign max_fitness      = max_seen;
  assign min_fitness      = min_seen;
  assign avg_fitness      = avg;
  assign best_index       = max_position;
  assign running_total    = total_q;
  assign last_result      = is_last_idx;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lfs_pkg::CNT_W'(index) < item_count))
    else $error("result index beyond loaded count");
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> (in_ready && item_count == '0))
    else $error("final word did not return to load");
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (min_seen <= max_seen))
    else $error("min above max after load");

endmodule
